// ===== design/pd_position_drive_with_settle_assert.svh =====
// assertion helpers for the position drive block
`ifndef PD_POSITION_DRIVE_WITH_SETTLE_ASSERT_SVH
`define PD_POSITION_DRIVE_WITH_SETTLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PDWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pd drive check failed");

// next-cycle implication, checked outside reset
`define PDWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pd drive check failed");

`endif

// ===== design/pdws_pkg.sv =====
package pdws_pkg;

  // configuration register indexes
  localparam logic [7:0] REG_PROP_GAIN    = 8'd0;
  localparam logic [7:0] REG_DERIV_GAIN   = 8'd1;
  localparam logic [7:0] REG_DRIVE_LIMIT  = 8'd2;
  localparam logic [7:0] REG_SETTLE_THRSH = 8'd3;

  // register reset values
  localparam logic [15:0] PROP_GAIN_RST    = 16'd1843;
  localparam logic [15:0] DERIV_GAIN_RST   = 16'd819;
  localparam logic [7:0]  DRIVE_LIMIT_RST  = 8'd255;
  localparam logic [7:0]  SETTLE_THRSH_RST = 8'd10;

  // datapath widths
  localparam int COUNT_W = 24;
  localparam int ERR_W   = 25;
  localparam int DELTA_W = 26;
  localparam int GAIN_W  = 16;
  localparam int DUTY_W  = 8;
  localparam int FRAC_W  = 12;
  localparam int T_W     = 43;
  localparam int WHOLE_W = T_W - FRAC_W;

  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [T_W-1:0]     term_t;
  typedef logic [DUTY_W-1:0]         duty_t;

endpackage

// ===== design/pd_position_drive_with_settle.sv =====
// PD position drive with settle detection. Each input beat carries a reference
// and a measured encoder count; the block returns one result beat per input
// with the drive direction, the 8-bit duty saturated to drive_limit, and the
// settle flags. The datapath is a three-register pipeline (error/delta, the
// two gain products, then combine/saturate/window), and out_valid rises once
// a beat has passed through all three registers; a new input can be taken
// every cycle while out_stall does not hold the pipeline, and a result
// waiting on out_stall backs up the pipeline one stage at a time. The error
// history is updated at acceptance, so consecutive items chain without
// bubbles. Every WINDOW_LEN results one carries window_done, with settled set
// when the window's duty sum was below settle_threshold * WINDOW_LEN.
// Configuration writes are always ready and must be made while the block is idle.
module pd_position_drive_with_settle
  import pdws_pkg::*;
#(
  parameter int WINDOW_LEN = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COUNT_W-1:0] in_ref_count,
  input  logic signed [COUNT_W-1:0] in_measured_count,
  input  logic                      in_new_ref,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_direction,
  output logic [DUTY_W-1:0]         out_drive_magnitude,
  output logic                      out_window_done,
  output logic                      out_settled,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data
);

  localparam int SUM_W  = $clog2(WINDOW_LEN * 255 + 1);
  localparam int FILL_W = $clog2(WINDOW_LEN);

  // configuration registers
  logic [GAIN_W-1:0] prop_gain_r;
  logic [GAIN_W-1:0] deriv_gain_r;
  duty_t             drive_limit_r;
  duty_t             settle_thrsh_r;

  // pipeline control
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_free, s1_free, in_accept;

  // stage payloads and state
  err_t   last_error_r;
  err_t   err_nxt;
  delta_t delta_nxt;
  err_t   s1_err_r;
  delta_t s1_delta_r;
  term_t  prod_p_nxt, prod_d_nxt;
  term_t  s2_prod_p_r, s2_prod_d_r;
  logic [SUM_W-1:0]  window_sum_r, sum_nxt, thrsh_total;
  logic [FILL_W-1:0] window_fill_r;

  // stage three combine
  term_t              t_val;
  logic [T_W-1:0]     t_mag;
  logic [WHOLE_W-1:0] whole;
  duty_t              duty;
  logic               win_done;

  logic        out_direction_r;
  duty_t       out_drive_magnitude_r;
  logic        out_window_done_r;
  logic        out_settled_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      drive_limit_r  <= DRIVE_LIMIT_RST;
      settle_thrsh_r <= SETTLE_THRSH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROP_GAIN:    prop_gain_r    <= cfg_data;
        REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data;
        REG_DRIVE_LIMIT:  drive_limit_r  <= cfg_data[DUTY_W-1:0];
        REG_SETTLE_THRSH: settle_thrsh_r <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: each stage moves when the one after it is empty or moving
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_r  <= in_valid;
      if (s2_free)  s2_valid_r  <= s1_valid_r;
      if (out_free) out_valid_r <= s2_valid_r;
    end
  end

  // stage one: error and change of error
  always_comb begin
    err_nxt   = ERR_W'(in_ref_count) - ERR_W'(in_measured_count);
    delta_nxt = in_new_ref ? '0 : (DELTA_W'(err_nxt) - DELTA_W'(last_error_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
    end else if (in_accept) begin
      last_error_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_err_r   <= err_nxt;
      s1_delta_r <= delta_nxt;
    end
  end

  // stage two: the two gain products
  always_comb begin
    prod_p_nxt = T_W'(signed'({1'b0, prop_gain_r})) * T_W'(s1_err_r);
    prod_d_nxt = T_W'(signed'({1'b0, deriv_gain_r})) * T_W'(s1_delta_r);
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      s2_prod_p_r <= prod_p_nxt;
      s2_prod_d_r <= prod_d_nxt;
    end
  end

  // stage three: aggregate, magnitude, saturation and window
  always_comb begin
    t_val       = s2_prod_p_r - s2_prod_d_r;
    t_mag       = t_val[T_W-1] ? T_W'(-t_val) : T_W'(t_val);
    whole       = t_mag[T_W-1:FRAC_W];
    duty        = (whole > WHOLE_W'(drive_limit_r)) ? drive_limit_r : whole[DUTY_W-1:0];
    sum_nxt     = window_sum_r + SUM_W'(duty);
    win_done    = (window_fill_r == FILL_W'(WINDOW_LEN - 1));
    thrsh_total = SUM_W'(settle_thrsh_r) * SUM_W'(WINDOW_LEN);
  end

  wire s3_load = out_free && s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_sum_r  <= '0;
      window_fill_r <= '0;
    end else if (s3_load) begin
      if (win_done) begin
        window_sum_r  <= '0;
        window_fill_r <= '0;
      end else begin
        window_sum_r  <= sum_nxt;
        window_fill_r <= window_fill_r + FILL_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_direction_r       <= t_val[T_W-1];
      out_drive_magnitude_r <= duty;
      out_window_done_r     <= win_done;
      out_settled_r         <= win_done && (sum_nxt < thrsh_total);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_direction       = out_direction_r;
  assign out_drive_magnitude = out_drive_magnitude_r;
  assign out_window_done     = out_window_done_r;
  assign out_settled         = out_settled_r;

`include "pd_position_drive_with_settle_assert.svh"

  // settled only reported on a beat that closes a window
  `PDWS_ASSERT_NOW(a_settled_needs_done, out_valid_r && out_settled_r, out_window_done_r)
  // duty never exceeds the limit
  `PDWS_ASSERT_NOW(a_duty_limit, out_valid_r, out_drive_magnitude_r <= drive_limit_r)
  // fill counter stays inside the window
  `PDWS_ASSERT_NOW(a_fill_range, 1'b1, window_fill_r <= FILL_W'(WINDOW_LEN - 1))
  // an accepted beat always lands in stage one
  `PDWS_ASSERT_NEXT(a_accept_lands, in_accept, s1_valid_r)
  // a stalled result is held in place
  `PDWS_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_drive_magnitude_r))

endmodule
